>>> rtl/core/fisc_pkg.sv
// Shared types and constants for the firmware image segment checker.
// Used by fisc_queue, fisc_engine and the top level; no dependencies.
package fisc_pkg;

  localparam logic [7:0]  MagicByte   = 8'hE9;
  localparam logic [7:0]  XorSeed     = 8'hEF;
  localparam logic [31:0] DramStart   = 32'h3FFE8000;
  localparam logic [32:0] DramEnd     = 33'h040000000;
  localparam logic [31:0] IramStart   = 32'h40100000;
  localparam logic [32:0] IramEnd     = 33'h040110000;
  localparam logic [3:0]  PadNibble   = 4'hF;

  localparam logic [2:0] RegImageBase  = 3'd0;
  localparam logic [2:0] RegImageLimit = 3'd1;
  localparam logic [2:0] RegBootSector = 3'd2;
  localparam logic [2:0] RegIromBase   = 3'd3;
  localparam logic [2:0] RegIromLength = 3'd4;
  localparam logic [2:0] RegSkipStart  = 3'd5;
  localparam logic [2:0] RegSkipEnd    = 3'd6;

  typedef enum logic [3:0] {
    ST_BUSY     = 4'd0,
    ST_OK       = 4'd1,
    ST_MAGIC    = 4'd2,
    ST_COUNT    = 4'd3,
    ST_ENTRY    = 4'd4,
    ST_REGION   = 4'd5,
    ST_OVERLAP  = 4'd6,
    ST_LIMIT    = 4'd7,
    ST_CHECKSUM = 4'd8,
    ST_TOOLONG  = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SEGHDR  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_PAD     = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    E_RUN    = 2'd0,
    E_REGION = 2'd1,
    E_WALK   = 2'd2,
    E_FINAL  = 2'd3
  } eng_state_t;

  typedef struct packed {
    logic        first;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [23:0] image_base;
    logic [24:0] image_limit;
    logic        require_boot_sector;
    logic [31:0] irom_base;
    logic [31:0] irom_length;
    logic [23:0] skip_start;
    logic [24:0] skip_end;
  } cfg_t;

endpackage

>>> rtl/core/fisc_queue.sv
// Front part: two-entry queue that accepts input items ahead of the engine.
// Depends on fisc_pkg for item_t.
module fisc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fisc_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_pop,
  output fisc_pkg::item_t out_item
);

  fisc_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/fisc_engine.sv
// Back part: byte-level image check, span walk and result register.
// Depends on fisc_pkg for item, config, status and phase types.
module fisc_engine #(
  parameter int SECTOR_BYTES = 4096,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  fisc_pkg::cfg_t  cfg,
  input  logic            item_valid,
  output logic            item_pop,
  input  fisc_pkg::item_t item,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [3:0]      res_status,
  output logic [24:0]     res_end
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  fisc_pkg::eng_state_t state, state_next;
  fisc_pkg::phase_t     phase, phase_next;
  fisc_pkg::status_t    latched, latched_next;
  logic [2:0]  fcount, fcount_next;
  logic [63:0] shift, shift_next;
  logic [4:0]  seg_total, seg_total_next;
  logic [4:0]  seg_num, seg_num_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [24:0] position, position_next;
  logic [7:0]  xsum, xsum_next;
  logic [31:0] seg_addr, seg_addr_next;
  logic [31:0] seg_size, seg_size_next;
  logic [31:0] seg_end, seg_end_next;
  logic [IW-1:0] walk_idx, walk_idx_next;
  logic [63:0] spans [MAX_SEGMENTS];
  logic        span_we;

  logic        emit;
  logic        out_free;

  // Effective state after an optional restart on a first-marked item
  fisc_pkg::phase_t  e_phase;
  fisc_pkg::status_t e_latched;
  logic [2:0]  e_fcount;
  logic [63:0] e_shift;
  logic [4:0]  e_seg_total, e_seg_num;
  logic [31:0] e_bytes_left;
  logic [24:0] e_position;
  logic [7:0]  e_xsum;

  logic [63:0] sh_new;
  logic [24:0] pos_inc;
  logic [31:0] bl_dec;
  logic [4:0]  num_inc;
  logic [7:0]  cnt_byte;
  logic [31:0] entry;
  logic [32:0] end33, irom_end33;
  logic        span_ok;
  logic [31:0] sp_s, sp_e;

  assign out_free = !res_valid || res_ready;

  always_comb begin
    if (item.first) begin
      e_phase      = fisc_pkg::PH_HEADER;
      e_latched    = fisc_pkg::ST_BUSY;
      e_fcount     = 3'd0;
      e_shift      = 64'd0;
      e_seg_total  = 5'd0;
      e_seg_num    = 5'd0;
      e_bytes_left = 32'd0;
      e_position   = {1'b0, cfg.image_base};
      e_xsum       = fisc_pkg::XorSeed;
    end else begin
      e_phase      = phase;
      e_latched    = latched;
      e_fcount     = fcount;
      e_shift      = shift;
      e_seg_total  = seg_total;
      e_seg_num    = seg_num;
      e_bytes_left = bytes_left;
      e_position   = position;
      e_xsum       = xsum;
    end
  end

  assign sh_new   = e_shift | ({56'd0, item.data_byte} << {e_fcount, 3'b000});
  assign pos_inc  = e_position + 25'd1;
  assign bl_dec   = e_bytes_left - 32'd1;
  assign num_inc  = e_seg_num + 5'd1;
  assign cnt_byte = sh_new[15:8];
  assign entry    = sh_new[63:32];

  assign end33      = {1'b0, seg_addr} + {1'b0, seg_size};
  assign irom_end33 = {1'b0, cfg.irom_base} + {1'b0, cfg.irom_length};
  always_comb begin
    span_ok = 1'b0;
    if (seg_size != 32'd0 && !end33[32]) begin
      if (seg_addr >= fisc_pkg::DramStart && end33 <= fisc_pkg::DramEnd) span_ok = 1'b1;
      if (seg_addr >= fisc_pkg::IramStart && end33 <= fisc_pkg::IramEnd) span_ok = 1'b1;
      if (cfg.irom_length != 32'd0 && !irom_end33[32] && seg_addr >= cfg.irom_base &&
          end33 <= irom_end33) span_ok = 1'b1;
    end
  end

  assign sp_s = spans[walk_idx][31:0];
  assign sp_e = spans[walk_idx][63:32];

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    latched_next    = latched;
    fcount_next     = fcount;
    shift_next      = shift;
    seg_total_next  = seg_total;
    seg_num_next    = seg_num;
    bytes_left_next = bytes_left;
    position_next   = position;
    xsum_next       = xsum;
    seg_addr_next   = seg_addr;
    seg_size_next   = seg_size;
    seg_end_next    = seg_end;
    walk_idx_next   = walk_idx;
    item_pop        = 1'b0;
    emit            = 1'b0;
    span_we         = 1'b0;

    unique case (state)
      fisc_pkg::E_RUN: begin
        if (item_valid && out_free) begin
          item_pop        = 1'b1;
          emit            = 1'b1;
          phase_next      = e_phase;
          latched_next    = e_latched;
          fcount_next     = e_fcount;
          shift_next      = e_shift;
          seg_total_next  = e_seg_total;
          seg_num_next    = e_seg_num;
          bytes_left_next = e_bytes_left;
          position_next   = e_position;
          xsum_next       = e_xsum;
          if (e_latched == fisc_pkg::ST_BUSY) begin
            unique case (e_phase)
              fisc_pkg::PH_HEADER, fisc_pkg::PH_SEGHDR: begin
                shift_next    = sh_new;
                fcount_next   = e_fcount + 3'd1;
                position_next = pos_inc;
                if (e_fcount == 3'd7) begin
                  if (e_phase == fisc_pkg::PH_HEADER) begin
                    if (sh_new[7:0] != fisc_pkg::MagicByte) begin
                      latched_next = fisc_pkg::ST_MAGIC;
                      phase_next   = fisc_pkg::PH_DONE;
                    end else if (cnt_byte == 8'd0 || cnt_byte > 8'(MAX_SEGMENTS)) begin
                      latched_next = fisc_pkg::ST_COUNT;
                      phase_next   = fisc_pkg::PH_DONE;
                    end else if (entry < fisc_pkg::IramStart ||
                                 {1'b0, entry} >= fisc_pkg::IramEnd) begin
                      latched_next = fisc_pkg::ST_ENTRY;
                      phase_next   = fisc_pkg::PH_DONE;
                    end else begin
                      seg_total_next = cnt_byte[4:0];
                      seg_num_next   = 5'd0;
                      fcount_next    = 3'd0;
                      shift_next     = 64'd0;
                      if ({1'b0, pos_inc} + 26'd8 > {1'b0, cfg.image_limit}) begin
                        latched_next = fisc_pkg::ST_LIMIT;
                        phase_next   = fisc_pkg::PH_DONE;
                      end else begin
                        phase_next = fisc_pkg::PH_SEGHDR;
                      end
                    end
                  end else begin
                    // hold the result until the span checks finish
                    emit          = 1'b0;
                    seg_addr_next = sh_new[31:0];
                    seg_size_next = sh_new[63:32];
                    state_next    = fisc_pkg::E_REGION;
                  end
                end
              end
              fisc_pkg::PH_PAYLOAD: begin
                if (e_position < {1'b0, cfg.skip_start} || e_position >= cfg.skip_end) begin
                  xsum_next = e_xsum ^ item.data_byte;
                end
                position_next   = pos_inc;
                bytes_left_next = bl_dec;
                if (bl_dec == 32'd0) begin
                  seg_num_next = num_inc;
                  if (num_inc < e_seg_total) begin
                    fcount_next = 3'd0;
                    shift_next  = 64'd0;
                    if ({1'b0, pos_inc} + 26'd8 > {1'b0, cfg.image_limit}) begin
                      latched_next = fisc_pkg::ST_LIMIT;
                      phase_next   = fisc_pkg::PH_DONE;
                    end else begin
                      phase_next = fisc_pkg::PH_SEGHDR;
                    end
                  end else if ((pos_inc | 25'h00000F) >= cfg.image_limit) begin
                    latched_next = fisc_pkg::ST_LIMIT;
                    phase_next   = fisc_pkg::PH_DONE;
                  end else begin
                    phase_next = fisc_pkg::PH_PAD;
                  end
                end
              end
              fisc_pkg::PH_PAD: begin
                position_next = pos_inc;
                if (e_position[3:0] == fisc_pkg::PadNibble) begin
                  phase_next = fisc_pkg::PH_DONE;
                  if (item.data_byte != e_xsum) begin
                    latched_next = fisc_pkg::ST_CHECKSUM;
                  end else if (cfg.require_boot_sector &&
                               pos_inc > 25'(SECTOR_BYTES)) begin
                    latched_next = fisc_pkg::ST_TOOLONG;
                  end else begin
                    latched_next = fisc_pkg::ST_OK;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      fisc_pkg::E_REGION: begin
        seg_end_next  = end33[31:0];
        walk_idx_next = '0;
        if (!span_ok) begin
          latched_next = fisc_pkg::ST_REGION;
          phase_next   = fisc_pkg::PH_DONE;
          emit         = 1'b1;
          state_next   = fisc_pkg::E_RUN;
        end else if (seg_num == 5'd0) begin
          state_next = fisc_pkg::E_FINAL;
        end else begin
          state_next = fisc_pkg::E_WALK;
        end
      end
      fisc_pkg::E_WALK: begin
        if (seg_addr < sp_e && sp_s < seg_end) begin
          latched_next = fisc_pkg::ST_OVERLAP;
          phase_next   = fisc_pkg::PH_DONE;
          emit         = 1'b1;
          state_next   = fisc_pkg::E_RUN;
        end else if (5'(walk_idx) + 5'd1 == seg_num) begin
          state_next = fisc_pkg::E_FINAL;
        end else begin
          walk_idx_next = walk_idx + 1'b1;
        end
      end
      fisc_pkg::E_FINAL: begin
        span_we    = 1'b1;
        emit       = 1'b1;
        state_next = fisc_pkg::E_RUN;
        if ({8'd0, position} + {1'b0, seg_size} > {8'd0, cfg.image_limit}) begin
          latched_next = fisc_pkg::ST_LIMIT;
          phase_next   = fisc_pkg::PH_DONE;
        end else begin
          bytes_left_next = seg_size;
          phase_next      = fisc_pkg::PH_PAYLOAD;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (span_we) begin
      spans[seg_num[IW-1:0]] <= {seg_end, seg_addr};
    end
    seg_addr <= seg_addr_next;
    seg_size <= seg_size_next;
    seg_end  <= seg_end_next;
    walk_idx <= walk_idx_next;
    if (emit) begin
      res_status <= latched_next;
      res_end    <= (latched_next == fisc_pkg::ST_OK) ? position_next : 25'd0;
    end
    if (rst) begin
      state      <= fisc_pkg::E_RUN;
      phase      <= fisc_pkg::PH_HEADER;
      latched    <= fisc_pkg::ST_BUSY;
      fcount     <= 3'd0;
      shift      <= 64'd0;
      seg_total  <= 5'd0;
      seg_num    <= 5'd0;
      bytes_left <= 32'd0;
      position   <= 25'd0;
      xsum       <= fisc_pkg::XorSeed;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      latched    <= latched_next;
      fcount     <= fcount_next;
      shift      <= shift_next;
      seg_total  <= seg_total_next;
      seg_num    <= seg_num_next;
      bytes_left <= bytes_left_next;
      position   <= position_next;
      xsum       <= xsum_next;
      if (emit) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> out_free) else $error("item taken while result register is full");
  a_pop_only_run: assert property (@(posedge clk) disable iff (rst)
    state != fisc_pkg::E_RUN |-> !item_pop) else $error("item taken during span walk");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == fisc_pkg::E_WALK |-> 5'(walk_idx) < seg_num) else $error("walk past last span");
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != fisc_pkg::ST_OK |-> res_end == 25'd0)
    else $error("image end shown without acceptance");

endmodule

>>> rtl/core/firmware_image_segment_checker.sv
// Boot image segment checker: one image byte per item in, one status per item out.
// Slave stream: tdata = data_byte, tuser = first (restarts the check at this byte).
// Master stream: tdata = {3'b0, end_offset[24:0], status[3:0]}, one result per input item.
// Status 0 means busy; the first verdict (ok or an error code) repeats until the
// next first-marked item. end_offset is nonzero only with status ok.
// A two-entry queue takes items ahead of the checking engine; the engine holds
// its result in an output register, so the input keeps flowing while it waits.
// Most bytes are checked as the engine takes them, and the result is registered. For the eighth
// byte of a segment header the engine steps through E_REGION, E_WALK (skipped for the first segment) and
// E_FINAL: in E_WALK it compares the new span with each stored span, one a cycle.
// Throughput is one item per cycle outside segment headers while the master accepts results.
// Reset (rst, synchronous) empties the queue, loads register defaults and
// starts an image at offset 0. When the master stalls, the result holds,
// the queue fills and tready drops after two more items.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect next cycle.
module firmware_image_segment_checker #(
  parameter int SECTOR_BYTES = 4096,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[3:0], end_offset[28:4], zero[31:29]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  fisc_pkg::cfg_t  cfg;
  fisc_pkg::item_t in_item;
  fisc_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;
  logic [3:0]      res_status;
  logic [24:0]     res_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_base          <= 24'd0;
      cfg.image_limit         <= 25'd4096;
      cfg.require_boot_sector <= 1'b1;
      cfg.irom_base           <= 32'd0;
      cfg.irom_length         <= 32'd0;
      cfg.skip_start          <= 24'd0;
      cfg.skip_end            <= 25'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fisc_pkg::RegImageBase:  cfg.image_base          <= cfg_wdata[23:0];
        fisc_pkg::RegImageLimit: cfg.image_limit         <= cfg_wdata[24:0];
        fisc_pkg::RegBootSector: cfg.require_boot_sector <= cfg_wdata[0];
        fisc_pkg::RegIromBase:   cfg.irom_base           <= cfg_wdata;
        fisc_pkg::RegIromLength: cfg.irom_length         <= cfg_wdata;
        fisc_pkg::RegSkipStart:  cfg.skip_start          <= cfg_wdata[23:0];
        fisc_pkg::RegSkipEnd:    cfg.skip_end            <= cfg_wdata[24:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.first     = s_axis_tuser;
  assign in_item.data_byte = s_axis_tdata;

  fisc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_item  (q_item)
  );

  fisc_engine #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item_pop   (q_pop),
    .item       (q_item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_status (res_status),
    .res_end    (res_end)
  );

  assign m_axis_tdata = {3'b000, res_end, res_status};

endmodule
